@@ rtl/core/drnl_pkg.sv @@
// Shared types, register indexes, constants and helper functions of the DRNL channel.
// Used by every module of the channel; depends on nothing else.
package drnl_pkg;

   // Configuration bank: eight 64-bit registers.
   localparam int CFG_REGS = 8;
   localparam int CFG_IDX_W = $clog2(CFG_REGS);
   typedef logic [63:0] cfg_bank_type [CFG_REGS];

   localparam logic [CFG_IDX_W-1:0] CFG_LIN_FF   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_LIN_FB   = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_NL_FF    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_NL_FB    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_KNEE     = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_RECIP    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_EFFERENT = 3'd7;

   // Accumulator width of the shared multiply unit.
   localparam int ACC_W = 48;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
   localparam logic [30:0] ATT_ONE = 31'h7FFF_FFFF;

   // Scaling applied to a product before it is accumulated.
   typedef enum logic [1:0] {
      SH_24,
      SH_28,
      SH_30,
      SH_31
   } shift_type;

   // Control word for the shared multiply-accumulate unit.
   typedef struct packed {
      logic      issue;
      logic      sub;
      logic      trunc;
      logic      clear;
      shift_type shift;
   } mac_ctl_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EFF,
      ST_LIN1,
      ST_GX1,
      ST_GX,
      ST_LIN2,
      ST_NL1,
      ST_NL2,
      ST_CMP_LIN,
      ST_CMP_T,
      ST_CMP_U,
      ST_NORM,
      ST_LOG,
      ST_CMP_E,
      ST_EXP,
      ST_EXP_SH,
      ST_CMP_C,
      ST_POST1,
      ST_POST2,
      ST_FINAL
   } state_type;

   // Square-root chain 2^(2^-k), k = 1..24, in Q2.30.
   localparam int ROOTS = 24;
   typedef logic [31:0] root_table_type [ROOTS];

   function automatic root_table_type root_table_f();
      root_table_type tab;
      logic [63:0] r;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      int k;
      int i;
      r = 64'h8000_0000;
      for (k = 0; k < ROOTS; k++) begin
         v = r << 30;
         res = '0;
         for (i = 31; i >= 0; i--) begin
            bitv = 64'd1 << (2 * i);
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
         end
         r = res;
         tab[k] = r[31:0];
      end
      return tab;
   endfunction

   localparam root_table_type ROOT_TABLE = root_table_f();

   // Saturate an accumulator value to a signed 32-bit word.
   function automatic logic signed [31:0] sat32_f(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > ACC_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < ACC_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/drnl_cochlea_channel_unit.sv @@
// One channel of a dual resonance nonlinear cochlear filterbank.
// The req_ channel takes one word per sample: a middle-ear sample and the efferent
// drive, both signed Q8.24. The rsp_ channel returns one word per sample: the
// attenuated channel output (Q8.24) and the efferent attenuation (unsigned Q0.31).
// The csr_ port holds eight 64-bit coefficient registers at byte addresses 8*i;
// write them only while no sample is in flight.
// One shared multiply-accumulate unit carries every product. Above the compressor
// knee the sequence also runs the log2 normalize and squaring loop and the exp2
// root product, unless the scaled level is not positive. req_ready is high only
// while the sequencer is idle, so the next word is taken at the earliest in the
// cycle after the result is loaded; a word is only taken once the one before it
// is done. The attenuation divider runs beside the filters and is always done
// before the last product. A result waits in the output register while the
// receiver stalls; the next word is accepted meanwhile and its final step holds
// until the register frees.
// Reset clears the control and coefficient registers, the filter history and the
// efferent level.
module drnl_cochlea_channel_unit import drnl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample,
   input  logic signed [31:0] req_efferent_drive,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_channel_out,
   output logic [30:0]        rsp_attenuation,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   cfg_bank_type cfg_ff;
   logic [CFG_IDX_W-1:0] csr_idx;
   logic csr_write;

   logic               start, idle, out_free, out_load;
   logic signed [31:0] out_chan;
   logic [30:0]        out_att;
   mac_ctl_type        mac_ctl;
   logic signed [32:0] op_a, op_b;
   logic signed [ACC_W-1:0] mac_sum;
   logic               div_start, div_busy;
   logic [30:0]        div_level, div_quo;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_chan_ff;
   logic [30:0]        rsp_att_ff;

   // Configuration registers.
   assign csr_idx    = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = cfg_ff[csr_idx];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0};
      end else if (csr_write) begin
         cfg_ff[csr_idx] <= csr_pwdata;
      end
   end

   // Handshakes.
   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   drnl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sample    (req_sample),
      .drive     (req_efferent_drive),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .idle      (idle),
      .out_load  (out_load),
      .out_chan  (out_chan),
      .out_att   (out_att),
      .mac_ctl   (mac_ctl),
      .op_a      (op_a),
      .op_b      (op_b),
      .mac_sum   (mac_sum),
      .div_start (div_start),
      .div_level (div_level),
      .div_busy  (div_busy),
      .div_quo   (div_quo)
   );

   drnl_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .sum   (mac_sum)
   );

   drnl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .level    (div_level),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan_ff <= out_chan;
         rsp_att_ff  <= out_att;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_attenuation = rsp_att_ff;

`ifndef ASSERT_OFF
   // An accepted word keeps the sequencer busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("sequencer idle right after accepting a word");

   // A result is only loaded into a free output register.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending output word");

   // The divider is never restarted while it still works.
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("attenuation divider restarted while busy");
`endif

endmodule

@@ rtl/core/drnl_mac.sv @@
// Shared multiply-accumulate unit: one registered 33x33 product, rounded or truncated,
// scaled, and added to or subtracted from an accumulator. Depends on drnl_pkg.
module drnl_mac import drnl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic signed [32:0]      op_a,
   input  logic signed [32:0]      op_b,
   output logic signed [ACC_W-1:0] sum
);

   logic signed [65:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    pend_ff, sub_ff, trunc_ff;
   shift_type               shift_ff;
   logic signed [66:0]      rsum;
   logic signed [66:0]      shifted;
   logic signed [66:0]      half;
   logic signed [ACC_W-1:0] term;

   // Product register; its scaling controls travel alongside.
   always_ff @(posedge clock) begin
      prod_ff  <= op_a * op_b;
      sub_ff   <= ctl.sub;
      trunc_ff <= ctl.trunc;
      shift_ff <= ctl.shift;
   end

   // Round half up (or truncate) and scale the pending product.
   always_comb begin
      case (shift_ff)
         SH_24:   half = 67'sd1 <<< 23;
         SH_28:   half = 67'sd1 <<< 27;
         SH_30:   half = 67'sd1 <<< 29;
         SH_31:   half = 67'sd1 <<< 30;
         default: half = '0;
      endcase
      rsum = {prod_ff[65], prod_ff} + (trunc_ff ? 67'sd0 : half);
      case (shift_ff)
         SH_24:   shifted = rsum >>> 24;
         SH_28:   shifted = rsum >>> 28;
         SH_30:   shifted = rsum >>> 30;
         SH_31:   shifted = rsum >>> 31;
         default: shifted = '0;
      endcase
      term = shifted[ACC_W-1:0];
      if (!pend_ff) begin
         sum = acc_ff;
      end else if (sub_ff) begin
         sum = acc_ff - term;
      end else begin
         sum = acc_ff + term;
      end
      acc_in = ctl.clear ? '0 : sum;
   end

   // Accumulator and pending flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         pend_ff <= ctl.issue;
         acc_ff  <= acc_in;
      end
   end

endmodule

@@ rtl/core/drnl_div.sv @@
// Restoring divider for the efferent attenuation round(2^55 / (2^24 + level)),
// one quotient bit per cycle. Depends on drnl_pkg.
module drnl_div import drnl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] level,
   output logic        busy,
   output logic [30:0] quotient
);

   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff;
   logic [30:0] num_ff;
   logic [30:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [32:0] rem_sh;
   logic        qbit;

   assign den_in = {1'b0, level} + 32'h0100_0000;
   assign rem_sh = {rem_ff, num_ff[30]};
   assign qbit   = rem_sh >= {1'b0, den_ff};

   // Control: count down the quotient bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'd31;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 5'd1;
         busy_ff <= cnt_ff != 5'd1;
      end
   end

   // Datapath: the numerator's top part is 2^24 and its low bits are den/2.
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den_in;
         rem_ff <= 32'h0100_0000;
         num_ff <= den_in[31:1];
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
         num_ff <= {num_ff[29:0], 1'b0};
         quo_ff <= {quo_ff[29:0], qbit};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/drnl_ctrl.sv @@
// Sequencer and filter state of the DRNL channel: walks both paths, the compressor
// and the efferent stage through the shared multiply unit. Depends on drnl_pkg.
module drnl_ctrl import drnl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      sample,
   input  logic signed [31:0]      drive,
   input  cfg_bank_type            cfg,
   input  logic                    out_free,
   output logic                    idle,
   output logic                    out_load,
   output logic signed [31:0]      out_chan,
   output logic [30:0]             out_att,
   output mac_ctl_type             mac_ctl,
   output logic signed [32:0]      op_a,
   output logic signed [32:0]      op_b,
   input  logic signed [ACC_W-1:0] mac_sum,
   output logic                    div_start,
   output logic [30:0]             div_level,
   input  logic                    div_busy,
   input  logic [30:0]             div_quo
);

   localparam logic [2:0] SEC_LAST = 3'd4;
   localparam logic [4:0] ITER_LAST = 5'(ROOTS - 1);

   state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [4:0]  iter_ff, iter_in;
   logic signed [31:0] x_ff, x_in, drive_ff, drive_in;
   logic signed [31:0] tmp_a_ff, tmp_a_in, tmp_b_ff, tmp_b_in;
   logic [31:0] m_ff, m_in;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  nsh_ff, nsh_in;
   logic [30:0] mm_ff, mm_in;
   logic        neg_ff, neg_in, att_max_ff, att_max_in;

   // Filter history; index 1 is the newest output.
   logic signed [31:0] lin_in_prev_ff, lin_in_prev_in;
   logic signed [31:0] lin_first_ff [2], lin_first_in [2];
   logic signed [31:0] lin_second_ff [2], lin_second_in [2];
   logic signed [31:0] nl_in_prev_ff, nl_in_prev_in;
   logic signed [31:0] nl_pre_first_ff [2], nl_pre_first_in [2];
   logic signed [31:0] nl_pre_second_ff [2], nl_pre_second_in [2];
   logic signed [31:0] nl_comp_prev_ff, nl_comp_prev_in;
   logic signed [31:0] nl_post_first_ff [2], nl_post_first_in [2];
   logic signed [31:0] nl_post_second_ff [2], nl_post_second_in [2];
   logic signed [31:0] eff_level_ff, eff_level_in;

   logic [63:0] sec_ffw, sec_fbw;
   logic signed [31:0] sx, sx1, sy1, sy0;
   logic signed [31:0] res;
   logic signed [32:0] res_abs, tmp_abs;
   logic [32:0] sq;
   logic [4:0]  fidx;
   logic        fbit;
   logic signed [7:0] exp_int;
   logic signed [9:0] rshift;
   logic [30:0] att;

   assign res     = sat32_f(mac_sum);
   assign res_abs = res[31] ? -{res[31], res} : {res[31], res};
   assign tmp_abs = tmp_a_ff[31] ? -{tmp_a_ff[31], tmp_a_ff} : {tmp_a_ff[31], tmp_a_ff};
   assign sq      = mac_sum[32:0];
   assign fidx    = 5'(ITER_LAST) - iter_ff;
   assign fbit    = tmp_b_ff[fidx];
   assign exp_int = tmp_b_ff[31:24];
   assign rshift  = 10'sd6 - {{2{exp_int[7]}}, exp_int};
   assign att     = att_max_ff ? ATT_ONE : div_quo;
   assign idle    = state_ff == ST_IDLE;

   // Operands of the biquad-style section that the current state works on.
   always_comb begin
      sec_ffw = cfg[CFG_NL_FF];
      sec_fbw = cfg[CFG_NL_FB];
      sx  = '0;
      sx1 = '0;
      sy1 = '0;
      sy0 = '0;
      case (state_ff)
         ST_LIN1: begin
            sec_ffw = cfg[CFG_LIN_FF];
            sec_fbw = cfg[CFG_LIN_FB];
            sx  = x_ff;
            sx1 = lin_in_prev_ff;
            sy1 = lin_first_ff[1];
            sy0 = lin_first_ff[0];
         end
         ST_LIN2: begin
            sec_ffw = cfg[CFG_LIN_FF];
            sec_fbw = cfg[CFG_LIN_FB];
            sx  = tmp_a_ff;
            sx1 = tmp_b_ff;
            sy1 = lin_second_ff[1];
            sy0 = lin_second_ff[0];
         end
         ST_NL1: begin
            sx  = x_ff;
            sx1 = nl_in_prev_ff;
            sy1 = nl_pre_first_ff[1];
            sy0 = nl_pre_first_ff[0];
         end
         ST_NL2: begin
            sx  = nl_pre_first_ff[1];
            sx1 = nl_pre_first_ff[0];
            sy1 = nl_pre_second_ff[1];
            sy0 = nl_pre_second_ff[0];
         end
         ST_POST1: begin
            sx  = tmp_a_ff;
            sx1 = nl_comp_prev_ff;
            sy1 = nl_post_first_ff[1];
            sy0 = nl_post_first_ff[0];
         end
         ST_POST2: begin
            sx  = nl_post_first_ff[1];
            sx1 = nl_post_first_ff[0];
            sy1 = nl_post_second_ff[1];
            sy0 = nl_post_second_ff[0];
         end
         default: begin
            sx = '0;
         end
      endcase
   end

   // Next state, unit control and state updates.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      iter_in    = iter_ff;
      x_in       = x_ff;
      drive_in   = drive_ff;
      tmp_a_in   = tmp_a_ff;
      tmp_b_in   = tmp_b_ff;
      m_in       = m_ff;
      frac_in    = frac_ff;
      nsh_in     = nsh_ff;
      mm_in      = mm_ff;
      neg_in     = neg_ff;
      att_max_in = att_max_ff;
      lin_in_prev_in    = lin_in_prev_ff;
      lin_first_in      = lin_first_ff;
      lin_second_in     = lin_second_ff;
      nl_in_prev_in     = nl_in_prev_ff;
      nl_pre_first_in   = nl_pre_first_ff;
      nl_pre_second_in  = nl_pre_second_ff;
      nl_comp_prev_in   = nl_comp_prev_ff;
      nl_post_first_in  = nl_post_first_ff;
      nl_post_second_in = nl_post_second_ff;
      eff_level_in      = eff_level_ff;
      mac_ctl    = '0;
      op_a       = '0;
      op_b       = '0;
      div_start  = 1'b0;
      div_level  = res[30:0];
      out_load   = 1'b0;
      out_chan   = res;
      out_att    = att;

      // Section states share the four-term sequence followed by a drain step.
      if (state_ff == ST_LIN1 || state_ff == ST_LIN2 || state_ff == ST_NL1 ||
          state_ff == ST_NL2 || state_ff == ST_POST1 || state_ff == ST_POST2) begin
         if (cnt_ff != SEC_LAST) begin
            mac_ctl.issue = 1'b1;
            mac_ctl.shift = SH_28;
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff[1:0])
               2'd0: begin
                  op_a = {sec_ffw[63], sec_ffw[63:32]};
                  op_b = {sx[31], sx};
               end
               2'd1: begin
                  op_a = {sec_ffw[31], sec_ffw[31:0]};
                  op_b = {sx1[31], sx1};
               end
               2'd2: begin
                  op_a = {sec_fbw[63], sec_fbw[63:32]};
                  op_b = {sy1[31], sy1};
                  mac_ctl.sub = 1'b1;
               end
               default: begin
                  op_a = {sec_fbw[31], sec_fbw[31:0]};
                  op_b = {sy0[31], sy0};
                  mac_ctl.sub = 1'b1;
               end
            endcase
         end else begin
            mac_ctl.clear = 1'b1;
            cnt_in = '0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = sample;
               drive_in = drive;
               cnt_in   = '0;
               state_in = ST_EFF;
            end
         end

         // Efferent leaky integrator; for a positive level the divider then runs alongside.
         ST_EFF: begin
            mac_ctl.shift = SH_28;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {eff_level_ff[31], eff_level_ff};
               op_b = {cfg[CFG_EFFERENT][63], cfg[CFG_EFFERENT][63:32]};
               cnt_in = 3'd1;
            end else if (cnt_ff == 3'd1) begin
               mac_ctl.issue = 1'b1;
               op_a = {drive_ff[31], drive_ff};
               op_b = {cfg[CFG_EFFERENT][31], cfg[CFG_EFFERENT][31:0]};
               cnt_in = 3'd2;
            end else begin
               mac_ctl.clear = 1'b1;
               eff_level_in  = res;
               att_max_in    = res <= 32'sd0;
               div_start     = res > 32'sd0;
               cnt_in        = '0;
               state_in      = ST_LIN1;
            end
         end

         ST_LIN1: begin
            if (cnt_ff == SEC_LAST) begin
               tmp_a_in       = res;
               lin_in_prev_in = x_ff;
               state_in       = ST_GX1;
            end
         end

         // Linear gain on the older tap of the first linear section.
         ST_GX1: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_EXPONENT][31], cfg[CFG_EXPONENT][31:0]};
               op_b = {lin_first_ff[1][31], lin_first_ff[1]};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               tmp_b_in = res;
               cnt_in   = '0;
               state_in = ST_GX;
            end
         end

         // Linear gain on the new output; the first section's history advances.
         ST_GX: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_EXPONENT][31], cfg[CFG_EXPONENT][31:0]};
               op_b = {tmp_a_ff[31], tmp_a_ff};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear   = 1'b1;
               tmp_a_in        = res;
               lin_first_in[0] = lin_first_ff[1];
               lin_first_in[1] = tmp_a_ff;
               cnt_in          = '0;
               state_in        = ST_LIN2;
            end
         end

         ST_LIN2: begin
            if (cnt_ff == SEC_LAST) begin
               lin_second_in[0] = lin_second_ff[1];
               lin_second_in[1] = res;
               state_in         = ST_NL1;
            end
         end

         ST_NL1: begin
            if (cnt_ff == SEC_LAST) begin
               nl_in_prev_in      = x_ff;
               nl_pre_first_in[0] = nl_pre_first_ff[1];
               nl_pre_first_in[1] = res;
               state_in           = ST_NL2;
            end
         end

         // Second nonlinear section, then pick the compressor branch.
         ST_NL2: begin
            if (cnt_ff == SEC_LAST) begin
               nl_pre_second_in[0] = nl_pre_second_ff[1];
               nl_pre_second_in[1] = res;
               tmp_a_in = res;
               neg_in   = res[31];
               if (res_abs < $signed({cfg[CFG_KNEE][63], cfg[CFG_KNEE][63:32]})) begin
                  state_in = ST_CMP_LIN;
               end else begin
                  state_in = ST_CMP_T;
               end
            end
         end

         // Below the knee the compressor is a plain gain.
         ST_CMP_LIN: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_RECIP][31], cfg[CFG_RECIP][31:0]};
               op_b = {tmp_a_ff[31], tmp_a_ff};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               tmp_a_in = res;
               cnt_in   = '0;
               state_in = ST_POST1;
            end
         end

         ST_CMP_T: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = tmp_abs;
               op_b = {cfg[CFG_RECIP][63], cfg[CFG_RECIP][63:32]};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               tmp_b_in = res;
               cnt_in   = '0;
               state_in = ST_CMP_U;
            end
         end

         // u = A * t; a nonpositive u gives a zero compressor output.
         ST_CMP_U: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_RECIP][31], cfg[CFG_RECIP][31:0]};
               op_b = {tmp_b_ff[31], tmp_b_ff};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               cnt_in = '0;
               if (res <= 32'sd0) begin
                  tmp_a_in = '0;
                  state_in = ST_POST1;
               end else begin
                  m_in     = res;
                  nsh_in   = '0;
                  state_in = ST_NORM;
               end
            end
         end

         // Normalize u so that bit 30 leads, one place per cycle.
         ST_NORM: begin
            if (m_ff[30]) begin
               frac_in  = '0;
               iter_in  = '0;
               state_in = ST_LOG;
            end else begin
               m_in   = {m_ff[30:0], 1'b0};
               nsh_in = nsh_ff + 5'd1;
            end
         end

         // Fraction bits of log2 by repeated squaring of the mantissa.
         ST_LOG: begin
            mac_ctl.shift = SH_30;
            mac_ctl.trunc = 1'b1;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {1'b0, m_ff};
               op_b = {1'b0, m_ff};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               frac_in = {frac_ff[22:0], sq[31]};
               m_in    = sq[31] ? sq[32:1] : sq[31:0];
               cnt_in  = '0;
               if (iter_ff == ITER_LAST) begin
                  iter_in  = '0;
                  state_in = ST_CMP_E;
               end else begin
                  iter_in = iter_ff + 5'd1;
               end
            end
         end

         // e = C * log2(u).
         ST_CMP_E: begin
            mac_ctl.shift = SH_24;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_EXPONENT][63], cfg[CFG_EXPONENT][63:32]};
               op_b = {(8'sd6 - {3'b000, nsh_ff}), frac_ff};
               op_b[32] = op_b[31];
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               tmp_b_in = res;
               mm_in    = 31'h4000_0000;
               iter_in  = '0;
               cnt_in   = '0;
               state_in = ST_EXP;
            end
         end

         // 2^frac as a product of root constants; clear fraction bits are skipped.
         ST_EXP: begin
            mac_ctl.shift = SH_30;
            mac_ctl.trunc = 1'b1;
            if (cnt_ff == 3'd0 && fbit) begin
               mac_ctl.issue = 1'b1;
               op_a = {2'b00, mm_ff};
               op_b = {1'b0, ROOT_TABLE[iter_ff]};
               cnt_in = 3'd1;
            end else begin
               if (cnt_ff != 3'd0) begin
                  mac_ctl.clear = 1'b1;
                  mm_in = sq[30:0];
               end
               cnt_in = '0;
               if (iter_ff == ITER_LAST) begin
                  state_in = ST_EXP_SH;
               end else begin
                  iter_in = iter_ff + 5'd1;
               end
            end
         end

         // Integer part of the exponent: shift into Q8.24, saturating at the top.
         ST_EXP_SH: begin
            if (rshift < 10'sd0) begin
               tmp_b_in = SAT_MAX;
            end else if (rshift > 10'sd30) begin
               tmp_b_in = '0;
            end else begin
               tmp_b_in = {1'b0, mm_ff >> rshift[4:0]};
            end
            state_in = ST_CMP_C;
         end

         // Scale by ctbm and restore the sign of the input.
         ST_CMP_C: begin
            mac_ctl.shift = SH_24;
            mac_ctl.sub   = neg_ff;
            if (cnt_ff == 3'd0) begin
               mac_ctl.issue = 1'b1;
               op_a = {cfg[CFG_KNEE][31], cfg[CFG_KNEE][31:0]};
               op_b = {tmp_b_ff[31], tmp_b_ff};
               cnt_in = 3'd1;
            end else begin
               mac_ctl.clear = 1'b1;
               tmp_a_in = res;
               cnt_in   = '0;
               state_in = ST_POST1;
            end
         end

         ST_POST1: begin
            if (cnt_ff == SEC_LAST) begin
               nl_comp_prev_in     = tmp_a_ff;
               nl_post_first_in[0] = nl_post_first_ff[1];
               nl_post_first_in[1] = res;
               state_in            = ST_POST2;
            end
         end

         ST_POST2: begin
            if (cnt_ff == SEC_LAST) begin
               nl_post_second_in[0] = nl_post_second_ff[1];
               nl_post_second_in[1] = res;
               state_in             = ST_FINAL;
            end
         end

         // Attenuate the sum of both paths; hold until the divider is done and the output word is free.
         ST_FINAL: begin
            mac_ctl.shift = SH_31;
            if (cnt_ff == 3'd0) begin
               if (!div_busy) begin
                  mac_ctl.issue = 1'b1;
                  op_a = {lin_second_ff[1][31], lin_second_ff[1]}
                       + {nl_post_second_ff[1][31], nl_post_second_ff[1]};
                  op_b = {2'b00, att};
                  cnt_in = 3'd1;
               end
            end else if (out_free) begin
               mac_ctl.clear = 1'b1;
               out_load = 1'b1;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         iter_ff  <= iter_in;
      end
   end

   // Filter history and efferent level, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_in_prev_ff    <= '0;
         lin_first_ff      <= '{default: '0};
         lin_second_ff     <= '{default: '0};
         nl_in_prev_ff     <= '0;
         nl_pre_first_ff   <= '{default: '0};
         nl_pre_second_ff  <= '{default: '0};
         nl_comp_prev_ff   <= '0;
         nl_post_first_ff  <= '{default: '0};
         nl_post_second_ff <= '{default: '0};
         eff_level_ff      <= '0;
         att_max_ff        <= 1'b1;
      end else begin
         lin_in_prev_ff    <= lin_in_prev_in;
         lin_first_ff      <= lin_first_in;
         lin_second_ff     <= lin_second_in;
         nl_in_prev_ff     <= nl_in_prev_in;
         nl_pre_first_ff   <= nl_pre_first_in;
         nl_pre_second_ff  <= nl_pre_second_in;
         nl_comp_prev_ff   <= nl_comp_prev_in;
         nl_post_first_ff  <= nl_post_first_in;
         nl_post_second_ff <= nl_post_second_in;
         eff_level_ff      <= eff_level_in;
         att_max_ff        <= att_max_in;
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      drive_ff <= drive_in;
      tmp_a_ff <= tmp_a_in;
      tmp_b_ff <= tmp_b_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      nsh_ff   <= nsh_in;
      mm_ff    <= mm_in;
      neg_ff   <= neg_in;
   end

endmodule

@@ tb/drnl_cochlea_channel_unit_test.sv @@
// Self-checking testbench for the DRNL cochlea channel unit.
// Drives sample words and APB register writes, and predicts every result word.
// Depends on drnl_pkg and drnl_cochlea_channel_unit.
`timescale 1ns / 1ps

module drnl_cochlea_channel_unit_test;
   import drnl_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic signed [31:0] chan;
      logic [30:0]        att;
   } chan_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_sample;
   logic signed [31:0] req_efferent_drive;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_channel_out;
   logic [30:0]        rsp_attenuation;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [5:0]         csr_paddr;
   logic [63:0]        csr_pwdata;
   logic [63:0]        csr_prdata;
   logic               csr_pready;

   // Shadow copy of the coefficient bank and of the filter history.
   logic [63:0] coef_bank [CFG_REGS];
   longint lin_x1, nl_x1, comp_x1, eff_level;
   longint lin_y1 [2], lin_y2 [2], pre_y1 [2], pre_y2 [2], post_y1 [2], post_y2 [2];

   chan_word_type pending_words [$];
   int            err_count;
   longint        cycle_count = 0;
   int            stall_mode;
   int            gap_max;

   drnl_cochlea_channel_unit i_dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Fixed-point helpers of the predictor.
   // ---------------------------------------------------------------------
   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint mul_round(longint a, longint b, int sh);
      return (a * b + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint coef_hi(int r);
      return longint'($signed(coef_bank[r][63:32]));
   endfunction

   function automatic longint coef_lo(int r);
      return longint'($signed(coef_bank[r][31:0]));
   endfunction

   // One biquad-style section: y = b0*x + b1*x1 - a1*y[1] - a2*y[0].
   function automatic longint run_section(int ff, int fb, longint x, longint x1,
                                          longint y_new, longint y_old);
      longint acc;
      acc = mul_round(coef_hi(ff), x, 28) + mul_round(coef_lo(ff), x1, 28)
          - mul_round(coef_hi(fb), y_new, 28) - mul_round(coef_lo(fb), y_old, 28);
      return clip32(acc);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Base-2 logarithm of a positive Q8.24 value by normalization and squaring.
   function automatic longint log2_q24(longint u);
      int p;
      longint unsigned m;
      longint frac;
      p = 0;
      m = longint'(u);
      frac = 0;
      while (p < 62 && (m >> (p + 1)) != 0) p++;
      if (p <= 30) m = m << (30 - p);
      else m = m >> (p - 30);
      for (int k = 0; k < 24; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(p) - 24) * 16777216 + frac;
   endfunction

   // Power of two of a Q8.24 exponent from a product of square-root constants.
   function automatic longint exp2_q24(longint e);
      longint n;
      longint s;
      longint unsigned f;
      longint unsigned r;
      longint unsigned mm;
      n = e >>> 24;
      f = e - n * 16777216;
      r = 64'd1 << 31;
      mm = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         r = int_sqrt(r << 30);
         if (((f >> (24 - k)) & 1) != 0) mm = (mm * r) >> 30;
      end
      s = 6 - n;
      if (s < 0) return 64'sd2147483647;
      if (s >= 63) return 0;
      return clip32(longint'(mm >> s));
   endfunction

   // Broken-stick compressor: linear below the knee, power law above it.
   function automatic longint compress_q24(longint x);
      longint ax, t, u, e, p, c;
      ax = (x < 0) ? -x : x;
      if (ax < coef_hi(CFG_KNEE)) return clip32(mul_round(coef_lo(CFG_RECIP), x, 24));
      t = clip32(mul_round(ax, coef_hi(CFG_RECIP), 24));
      u = clip32(mul_round(coef_lo(CFG_RECIP), t, 24));
      if (u <= 0) return 0;
      e = clip32(mul_round(coef_hi(CFG_EXPONENT), log2_q24(u), 24));
      p = exp2_q24(e);
      c = mul_round(coef_lo(CFG_KNEE), p, 24);
      if (x < 0) c = -c;
      return clip32(c);
   endfunction

   // Advance the channel by one sample word and return the result word it gives.
   function automatic chan_word_type channel_step(longint x, longint drive);
      longint l1, l2, n1, n2, cp, p1, p2, gx, gx1, lvl, att, sum, prev;
      longint unsigned d;
      longint unsigned q;
      chan_word_type res;

      // Linear path; the gain scales both input taps of the second section.
      l1 = run_section(CFG_LIN_FF, CFG_LIN_FB, x, lin_x1, lin_y1[1], lin_y1[0]);
      lin_x1 = x;
      gx = clip32(mul_round(coef_lo(CFG_EXPONENT), l1, 24));
      gx1 = clip32(mul_round(coef_lo(CFG_EXPONENT), lin_y1[1], 24));
      lin_y1[0] = lin_y1[1];
      lin_y1[1] = l1;
      l2 = run_section(CFG_LIN_FF, CFG_LIN_FB, gx, gx1, lin_y2[1], lin_y2[0]);
      lin_y2[0] = lin_y2[1];
      lin_y2[1] = l2;

      // Nonlinear path before the compressor.
      n1 = run_section(CFG_NL_FF, CFG_NL_FB, x, nl_x1, pre_y1[1], pre_y1[0]);
      nl_x1 = x;
      prev = pre_y1[1];
      pre_y1[0] = pre_y1[1];
      pre_y1[1] = n1;
      n2 = run_section(CFG_NL_FF, CFG_NL_FB, n1, prev, pre_y2[1], pre_y2[0]);
      pre_y2[0] = pre_y2[1];
      pre_y2[1] = n2;

      // Efferent leaky integrator and the attenuation it sets.
      lvl = clip32(mul_round(eff_level, coef_hi(CFG_EFFERENT), 28)
                 + mul_round(drive, coef_lo(CFG_EFFERENT), 28));
      eff_level = lvl;
      if (lvl <= 0) begin
         att = 64'sh7FFFFFFF;
      end else begin
         d = longint'(lvl) + (64'd1 << 24);
         q = ((64'd1 << 55) + (d >> 1)) / d;
         att = (q > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(q);
      end

      // Compressor and the nonlinear sections after it.
      cp = compress_q24(n2);
      p1 = run_section(CFG_NL_FF, CFG_NL_FB, cp, comp_x1, post_y1[1], post_y1[0]);
      comp_x1 = cp;
      prev = post_y1[1];
      post_y1[0] = post_y1[1];
      post_y1[1] = p1;
      p2 = run_section(CFG_NL_FF, CFG_NL_FB, p1, prev, post_y2[1], post_y2[0]);
      post_y2[0] = post_y2[1];
      post_y2[1] = p2;

      sum = l2 + p2;
      res.chan = clip32(mul_round(sum, att, 31));
      res.att = att[30:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers.
   // ---------------------------------------------------------------------
   // Register write over APB: setup cycle, then access cycle.
   task automatic write_coef(input int idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 6'(idx * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      coef_bank[idx] = value;
      @(posedge clock);
   endtask

   // Let every outstanding word drain before touching the registers.
   task automatic wait_drained();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Present one sample word, hold it until accepted, then maybe idle.
   task automatic send_word(input logic [31:0] smp, input logic [31:0] drive);
      int gap;
      req_valid <= 1'b1;
      req_sample <= smp;
      req_efferent_drive <= drive;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(channel_step(longint'($signed(smp)),
                                           longint'($signed(drive))));
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result checker: compare every accepted word with the oldest prediction.
   always @(posedge clock) begin
      chan_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected result word out=%h att=%h", $time,
                     rsp_channel_out, rsp_attenuation);
            err_count++;
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp_channel_out !== exp_w.chan) begin
               $display("%0t: channel_out expected %h actual %h", $time,
                        exp_w.chan, rsp_channel_out);
               err_count++;
            end
            if (rsp_attenuation !== exp_w.att) begin
               $display("%0t: attenuation expected %h actual %h", $time,
                        exp_w.att, rsp_attenuation);
               err_count++;
            end
         end
      end
   end

   // Receiver stall pattern, switched per phase.
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= (cycle_count % 64) >= 40;
      endcase
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus generators.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] tame_coef();
      return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   // Load a bank of filter coefficients; wild selects fully random values.
   task automatic load_bank(input bit wild);
      for (int i = 0; i < CFG_REGS; i++) begin
         if (wild) write_coef(i, {$urandom(), $urandom()});
         else if (i == CFG_KNEE)
            write_coef(i, {32'($urandom_range(0, 32'h0100_0000)),
                           32'($urandom_range(0, 32'h0400_0000))});
         else if (i == CFG_RECIP || i == CFG_EXPONENT)
            write_coef(i, {32'($urandom_range(0, 32'h0200_0000)),
                           32'($urandom_range(0, 32'h0400_0000))});
         else if (i == CFG_EFFERENT)
            write_coef(i, {32'($urandom_range(0, 32'h1000_0000)),
                           32'($urandom_range(0, 32'h1000_0000))});
         else write_coef(i, {tame_coef(), tame_coef()});
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------
   // Reset state: every coefficient zero, output and attenuation at rest.
   task automatic test_reset_bank();
      send_word(32'h0100_0000, 32'h0100_0000);
      send_word(32'h8000_0000, 32'h7FFF_FFFF);
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Extremes of fields and registers: saturation, knee, zero and negative levels.
   task automatic test_extremes();
      for (int i = 0; i < CFG_REGS; i++) write_coef(i, 64'h7FFF_FFFF_7FFF_FFFF);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(32'h8000_0000, 32'h8000_0000);
      send_word(32'h0000_0000, 32'h0000_0000);
      req_valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < CFG_REGS; i++) write_coef(i, 64'h8000_0000_8000_0000);
      send_word(32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'h8000_0000, 32'h7FFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'h0000_0001);
      req_valid <= 1'b0;
      wait_drained();
      // Compressor above the knee with a tiny knee.
      load_bank(1'b0);
      write_coef(CFG_KNEE, {32'h0000_0001, 32'h0100_0000});
      send_word(32'h0100_0000, 32'h0100_0000);
      send_word(32'hFF00_0000, 32'h0000_0000);
      send_word(32'h0000_0001, 32'hFFFF_FFFF);
      req_valid <= 1'b0;
      wait_drained();
      // Nonpositive scaled level and zero output above the knee, then everything below a huge knee.
      write_coef(CFG_RECIP, {32'h0100_0000, 32'hFF00_0000});
      send_word(32'h0400_0000, 32'h0200_0000);
      send_word(32'hFC00_0000, 32'h0200_0000);
      req_valid <= 1'b0;
      wait_drained();
      write_coef(CFG_KNEE, {32'h7FFF_FFFF, 32'h0100_0000});
      send_word(32'h0400_0000, 32'h0000_0000);
      send_word(32'hFC00_0000, 32'h8000_0000);
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Random words under a number of register settings and idle patterns.
   task automatic test_random_phases();
      for (int ph = 0; ph < 6; ph++) begin
         stall_mode = ph % 3;
         gap_max = (ph < 3) ? 4 : 20;
         load_bank(ph == 5);
         for (int n = 0; n < 300; n++) send_word(any_word(), any_word());
         req_valid <= 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_efferent_drive = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      err_count = 0;
      stall_mode = 1;
      gap_max = 6;
      lin_x1 = 0;
      nl_x1 = 0;
      comp_x1 = 0;
      eff_level = 0;
      for (int i = 0; i < 2; i++) begin
         lin_y1[i] = 0;
         lin_y2[i] = 0;
         pre_y1[i] = 0;
         pre_y2[i] = 0;
         post_y1[i] = 0;
         post_y2[i] = 0;
      end
      for (int i = 0; i < CFG_REGS; i++) coef_bank[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_bank();
      test_extremes();
      test_random_phases();

      wait_drained();
      repeat (250) @(posedge clock);
      if (err_count == 0 && pending_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
